/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL that checks its own sequencing.
// Expects a clock named clk and an active-low asynchronous reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dpid_pkg.sv */
// Package for the discrete PID controller: sequencer states, register indexes,
// divider request/status structs and shared constants. No dependencies.
package dpid_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INC,
		ST_INTEG,
		ST_IE_LO,
		ST_IE_HI,
		ST_DMUL,
		ST_DIV_START,
		ST_DIV,
		ST_SUM,
		ST_U_LO,
		ST_U_HI,
		ST_DONE
	} dpid_state_t;

	localparam logic [1:0] REG_KP = 2'd0;
	localparam logic [1:0] REG_KI = 2'd1;
	localparam logic [1:0] REG_KD = 2'd2;
	localparam logic [1:0] REG_T0 = 2'd3;

	localparam logic [31:0] KP_RESET = 32'h0001_0000;
	localparam logic [31:0] T0_RESET = 32'h0001_0000;

	// index of the last quotient step of the divider, one quotient bit per cycle
	localparam logic [5:0] DIV_LAST_STEP = 6'd47;

	// intermediate term magnitude limit, 2^48 raw
	localparam logic [48:0] TERM_LIM = 49'h1_0000_0000_0000;

	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
	} dpid_div_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [47:0] quot;
	} dpid_div_sts_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

/* hw/rtl/dpid_div.sv */
// Restoring divider: trunc(num * 2^16 / den), one quotient bit per cycle.
// Flags overflow when the quotient reaches 2^48. Depends on dpid_pkg.
module dpid_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dpid_pkg::dpid_div_req_t req,
	output dpid_pkg::dpid_div_sts_t sts
);

	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	logic [5:0]  cnt_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        fits;
	logic        start_ovf;

	assign trial     = {rem_q, quo_q[47]};
	assign diff      = {1'b0, trial} - {2'b00, den_q};
	assign fits      = !diff[33];
	// quotient >= 2^48 exactly when num / 2^32 >= den
	assign start_ovf = {16'h0000, req.num[47:32]} >= req.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ovf_q  <= start_ovf;
				busy_q <= !start_ovf;
				done_q <= start_ovf;
			end else if (busy_q && cnt_q == dpid_pkg::DIV_LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= {16'h0000, req.num[47:32]};
			quo_q <= {req.num[31:0], 16'h0000};
			cnt_q <= 6'd0;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when it fits
			rem_q <= fits ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[46:0], fits};
			cnt_q <= cnt_q + 6'd1;
		end
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign sts.quot = quo_q;

endmodule

/* hw/rtl/discrete_pid_controller.sv */
// Positional discrete PID controller, u = K*(e + I*E + D*(e - e_prev)/T0), Q16.16.
// Each item runs the sequencer from INC to DONE, the DIV state being cut short when the
// derivative quotient overflows; a new item is taken only in IDLE, once the last result
// is loaded; the shared 32x32 multiplier and one-bit-per-cycle divider set the schedule.
// Reset: gains K=1.0, I=D=0, T0=1.0; error history and integral cleared, first-sample set.
`include "assert_macros.svh"

module discrete_pid_controller (
	input  logic               clk,
	input  logic               arst_n,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] target_speed,
	input  logic signed [15:0] measured_speed,
	// result item channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive_command,
	output logic               saturated,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers
	logic [31:0] kp_q;
	logic [31:0] ki_q;
	logic [31:0] kd_q;
	logic [31:0] t0_q;
	logic        cfg_wr;

	// Sequencer
	dpid_pkg::dpid_state_t state_q;
	dpid_pkg::dpid_state_t state_d;

	// Per-item working registers
	logic signed [16:0] e_q;
	logic signed [17:0] de_q;
	logic signed [47:0] integ_q;
	logic signed [49:0] ie_q;
	logic [49:0]        sum_mag_q;
	logic               sum_neg_q;
	logic [81:0]        acc_q;
	logic               sat_q;

	// Controller state carried across items
	logic signed [16:0] prev_q;
	logic signed [47:0] err_int_q;
	logic               first_q;

	// Result register
	logic               out_valid_q;
	logic signed [31:0] drive_command_q;
	logic               saturated_q;

	// Datapath signals
	logic [31:0] t0_eff;
	logic [16:0] e_mag;
	logic [49:0] inc_val;
	logic [16:0] prev_sel;
	logic [49:0] int_base;
	logic [49:0] integ_raw;
	logic        integ_ovf;
	logic [47:0] integ_clip;
	logic [17:0] de_val;
	logic [47:0] integ_mag;
	logic [17:0] de_abs;
	logic [65:0] ie_p;
	logic        ie_clip;
	logic [48:0] ie_mag;
	logic [49:0] ie_val;
	logic [48:0] dt_mag;
	logic [49:0] dt_val;
	logic [50:0] sum_val;
	logic [50:0] sum_abs;
	logic [65:0] u_p;
	logic        u_neg;
	logic [65:0] u_lim;
	logic        u_clip;
	logic [31:0] u_mag;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        in_accept;
	logic        out_load;

	dpid_pkg::dpid_div_req_t div_req;
	dpid_pkg::dpid_div_sts_t div_sts;

	// ------------------------------------------------------------------
	// Configuration port: zero wait states, written on the access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= dpid_pkg::KP_RESET;
			ki_q <= 32'd0;
			kd_q <= 32'd0;
			t0_q <= dpid_pkg::T0_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				dpid_pkg::REG_KP: kp_q <= pwdata;
				dpid_pkg::REG_KI: ki_q <= pwdata;
				dpid_pkg::REG_KD: kd_q <= pwdata;
				dpid_pkg::REG_T0: t0_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			dpid_pkg::REG_KP: prdata = kp_q;
			dpid_pkg::REG_KI: prdata = ki_q;
			dpid_pkg::REG_KD: prdata = kd_q;
			dpid_pkg::REG_T0: prdata = t0_q;
			default:          prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath terms
	// ------------------------------------------------------------------
	// A zero period counts as one LSB for both the integral and the division.
	assign t0_eff = (t0_q == 32'd0) ? 32'd1 : t0_q;
	assign e_mag  = e_q[16] ? (~e_q + 17'd1) : e_q;

	// Integral update: inc = T0*e, first sample starts from zero with e_prev = e.
	assign inc_val   = e_q[16] ? (~{2'b00, acc_q[47:0]} + 50'd1) : {2'b00, acc_q[47:0]};
	assign prev_sel  = first_q ? e_q : prev_q;
	assign int_base  = first_q ? 50'd0 : {{2{err_int_q[47]}}, err_int_q};
	assign integ_raw = int_base + inc_val;
	assign integ_ovf = !(integ_raw[49:47] == 3'b000 || integ_raw[49:47] == 3'b111);
	assign integ_clip = !integ_ovf ? integ_raw[47:0] :
		(integ_raw[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
	assign de_val    = {e_q[16], e_q} - {prev_sel[16], prev_sel};

	assign integ_mag = integ_q[47] ? (~integ_q + 48'd1) : integ_q;
	assign de_abs    = de_q[17] ? (~de_q + 18'd1) : de_q;

	// I*E term: drop 16 fraction bits, clip magnitude to 2^48.
	assign ie_p    = acc_q[81:16];
	assign ie_clip = ie_p > {17'd0, dpid_pkg::TERM_LIM};
	assign ie_mag  = ie_clip ? dpid_pkg::TERM_LIM : ie_p[48:0];
	assign ie_val  = (ki_q[31] ^ integ_q[47]) ? (~{1'b0, ie_mag} + 50'd1) : {1'b0, ie_mag};

	// D*(e - e_prev)/T0 term: an overflowing quotient clips to 2^48.
	assign dt_mag = div_sts.ovf ? dpid_pkg::TERM_LIM : {1'b0, div_sts.quot};
	assign dt_val = (kd_q[31] ^ de_q[17]) ? (~{1'b0, dt_mag} + 50'd1) : {1'b0, dt_mag};

	assign sum_val = {{18{e_q[16]}}, e_q, 16'h0000}
		+ {ie_q[49], ie_q} + {dt_val[49], dt_val};
	assign sum_abs = sum_val[50] ? (~sum_val + 51'd1) : sum_val;

	// Output: drop fraction bits, clip to the signed 32-bit range.
	assign u_p    = acc_q[81:16];
	assign u_neg  = kp_q[31] ^ sum_neg_q;
	assign u_lim  = u_neg ? 66'h0_8000_0000 : 66'h0_7FFF_FFFF;
	assign u_clip = u_p > u_lim;
	assign u_mag  = u_clip ? u_lim[31:0] : u_p[31:0];

	// ------------------------------------------------------------------
	// Shared unsigned 32x32 multiplier; operands are magnitudes
	// ------------------------------------------------------------------
	always_comb begin
		unique case (state_q)
			dpid_pkg::ST_INC: begin
				mul_a = t0_eff;
				mul_b = {15'd0, e_mag};
			end
			dpid_pkg::ST_IE_LO: begin
				mul_a = dpid_pkg::mag32(ki_q);
				mul_b = integ_mag[31:0];
			end
			dpid_pkg::ST_IE_HI: begin
				mul_a = dpid_pkg::mag32(ki_q);
				mul_b = {16'd0, integ_mag[47:32]};
			end
			dpid_pkg::ST_DMUL: begin
				mul_a = dpid_pkg::mag32(kd_q);
				mul_b = {15'd0, de_abs[16:0]};
			end
			dpid_pkg::ST_U_LO: begin
				mul_a = dpid_pkg::mag32(kp_q);
				mul_b = sum_mag_q[31:0];
			end
			dpid_pkg::ST_U_HI: begin
				mul_a = dpid_pkg::mag32(kp_q);
				mul_b = {14'd0, sum_mag_q[49:32]};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Derivative divider
	// ------------------------------------------------------------------
	assign div_req.start = (state_q == dpid_pkg::ST_DIV_START);
	assign div_req.num   = acc_q[47:0];
	assign div_req.den   = t0_eff;

	dpid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign in_stall  = (state_q != dpid_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	// hold the finished result until the output register frees up
	assign out_load  = (state_q == dpid_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpid_pkg::ST_IDLE:      if (in_valid) state_d = dpid_pkg::ST_INC;
			dpid_pkg::ST_INC:       state_d = dpid_pkg::ST_INTEG;
			dpid_pkg::ST_INTEG:     state_d = dpid_pkg::ST_IE_LO;
			dpid_pkg::ST_IE_LO:     state_d = dpid_pkg::ST_IE_HI;
			dpid_pkg::ST_IE_HI:     state_d = dpid_pkg::ST_DMUL;
			dpid_pkg::ST_DMUL:      state_d = dpid_pkg::ST_DIV_START;
			dpid_pkg::ST_DIV_START: state_d = dpid_pkg::ST_DIV;
			dpid_pkg::ST_DIV:       if (div_sts.done) state_d = dpid_pkg::ST_SUM;
			dpid_pkg::ST_SUM:       state_d = dpid_pkg::ST_U_LO;
			dpid_pkg::ST_U_LO:      state_d = dpid_pkg::ST_U_HI;
			dpid_pkg::ST_U_HI:      state_d = dpid_pkg::ST_DONE;
			dpid_pkg::ST_DONE:      if (out_load) state_d = dpid_pkg::ST_IDLE;
			default:                state_d = dpid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers: advance one step of the schedule per state
	always_ff @(posedge clk) begin
		unique case (state_q)
			dpid_pkg::ST_IDLE: begin
				if (in_accept) begin
					e_q   <= {target_speed[15], target_speed}
						- {measured_speed[15], measured_speed};
					sat_q <= 1'b0;
				end
			end
			dpid_pkg::ST_INC: begin
				acc_q <= {18'd0, prod};
			end
			dpid_pkg::ST_INTEG: begin
				integ_q <= integ_clip;
				de_q    <= de_val;
				sat_q   <= sat_q | integ_ovf;
			end
			dpid_pkg::ST_IE_LO: begin
				acc_q <= {18'd0, prod};
			end
			dpid_pkg::ST_IE_HI: begin
				acc_q <= acc_q + {prod[49:0], 32'd0};
			end
			dpid_pkg::ST_DMUL: begin
				ie_q  <= ie_val;
				sat_q <= sat_q | ie_clip;
				acc_q <= {18'd0, prod};
			end
			dpid_pkg::ST_SUM: begin
				sum_mag_q <= sum_abs[49:0];
				sum_neg_q <= sum_val[50];
				sat_q     <= sat_q | div_sts.ovf;
			end
			dpid_pkg::ST_U_LO: begin
				acc_q <= {18'd0, prod};
			end
			dpid_pkg::ST_U_HI: begin
				acc_q <= acc_q + {prod[49:0], 32'd0};
			end
			default: ;
		endcase
	end

	// Controller history: commit at the end of each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 17'sd0;
			err_int_q <= 48'sd0;
			first_q   <= 1'b1;
		end else if (out_load) begin
			prev_q    <= e_q;
			err_int_q <= integ_q;
			first_q   <= 1'b0;
		end
	end

	// Result register: drop valid once taken, reload on a finished item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_command_q <= u_neg ? (~u_mag + 32'd1) : u_mag;
			saturated_q     <= sat_q | u_clip;
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_command = drive_command_q;
	assign saturated     = saturated_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == dpid_pkg::ST_DONE, "result raised outside the final step")
	`ASSERT_IMPL(a_div_done_waiting, div_sts.done, state_q == dpid_pkg::ST_DIV, "divider finished while the sequencer was not waiting")
	`ASSERT_NEXT(a_accept_starts, in_accept, state_q == dpid_pkg::ST_INC, "accepted item did not start the schedule")
	`ASSERT_IMPL(a_first_cleared, $rose(out_valid_q), !first_q, "first-sample flag still set after a result")

endmodule
